### sv/lfpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED frame player package
// Shared types, codes and constants of the LED frame player with crossfade.
// ----------------------------------------------------------------------------
package lfpc_pkg;

	localparam int LFPC_MAX_FRAMES = 16;
	localparam int LFPC_MAX_ROWS   = 32;
	localparam int LFPC_MAX_COLS   = 32;

	// Width that holds any index or size up to 256.
	localparam int LFPC_EXT_W      = 9;

	localparam int LFPC_CFG_IDX_W  = 3;
	localparam int LFPC_CFG_DATA_W = 24;
	localparam int LFPC_NF_W       = 5;
	localparam int LFPC_ELAPSED_W  = 25;
	localparam int LFPC_PERIOD_W   = 24;
	localparam int LFPC_PIX_W      = 24;

	localparam logic [LFPC_NF_W-1:0]     LFPC_RST_NUM_FRAMES = 5'd1;
	localparam logic [LFPC_PERIOD_W-1:0] LFPC_RST_PERIOD     = 24'd100000;
	localparam logic [5:0]               LFPC_RST_ROWS       = 6'd32;
	localparam logic [5:0]               LFPC_RST_COLS       = 6'd32;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_TICK  = 2'd1,
		OP_READ  = 2'd2
	} lfpc_op_t;

	typedef enum logic [LFPC_CFG_IDX_W-1:0] {
		CFG_NUM_FRAMES   = 3'd0,
		CFG_FRAME_PERIOD = 3'd1,
		CFG_GRID_ROWS    = 3'd2,
		CFG_GRID_COLS    = 3'd3,
		CFG_PLAY_FORWARD = 3'd4,
		CFG_BLEND_ENABLE = 3'd5,
		CFG_PLAY_ENABLE  = 3'd6
	} lfpc_cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  frame_sel;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [15:0] dt;
	} lfpc_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_changed;
		logic       in_range;
		logic [3:0] current_frame;
	} lfpc_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lfpc_blend_sts_t;

endpackage
`default_nettype wire

### sv/lfpc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED frame player channels
// Valid/ready channels for requests into the player and results out of it.
// ----------------------------------------------------------------------------
interface lfpc_cmd_if;
	import lfpc_pkg::*;
	logic     valid;
	logic     ready;
	lfpc_in_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lfpc_rsp_if;
	import lfpc_pkg::*;
	logic      valid;
	logic      ready;
	lfpc_out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/lfpc_blend_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED frame player blend unit
// Finds the crossfade weight with a restoring divider, one quotient bit per
// cycle, then mixes the three channels through one shared multiplier.
// ----------------------------------------------------------------------------
module lfpc_blend_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [lfpc_pkg::LFPC_ELAPSED_W-1:0]  elapsed,
	input  logic [lfpc_pkg::LFPC_PERIOD_W-1:0]   period,
	input  logic [lfpc_pkg::LFPC_PIX_W-1:0]      cur_pix,
	input  logic [lfpc_pkg::LFPC_PIX_W-1:0]      nxt_pix,
	output logic [lfpc_pkg::LFPC_PIX_W-1:0]      mix_pix,
	output lfpc_pkg::lfpc_blend_sts_t            sts
);
	import lfpc_pkg::*;

	localparam logic [3:0] DIV_LAST = 4'd8;
	localparam logic [3:0] MIX_LAST = 4'd5;

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_DIV  = 3'b010,
		U_MIX  = 3'b100
	} ustate_t;

	ustate_t                     state_q;
	logic [3:0]                  cnt_q;
	logic                        done_q;
	logic [LFPC_ELAPSED_W-1:0]   rem_q;
	logic [LFPC_PERIOD_W-1:0]    per_q;
	logic [7:0]                  quo_q;
	logic                        sat_q;
	logic [16:0]                 acc_q;
	logic [LFPC_PIX_W-1:0]       mix_q;

	logic [LFPC_ELAPSED_W-1:0]   div_a;
	logic [LFPC_ELAPSED_W-1:0]   div_diff;
	logic                        div_ge;
	logic [8:0]                  w;
	logic [1:0]                  ch;
	logic [7:0]                  cur_ch;
	logic [7:0]                  nxt_ch;
	logic [7:0]                  mul_a;
	logic [8:0]                  mul_b;
	logic [16:0]                 prod;
	logic [16:0]                 sum;

	// The first divider step only tests for saturation; if it does not saturate, the
	// remainder is below the period and each later step doubles it.
	always_comb begin
		div_a    = (cnt_q == 4'd0) ? rem_q : {rem_q[LFPC_ELAPSED_W-2:0], 1'b0};
		div_ge   = div_a >= {1'b0, per_q};
		div_diff = div_a - {1'b0, per_q};
		w        = sat_q ? 9'd256 : {1'b0, quo_q};
		ch       = cnt_q[2:1];
		case (ch)
			2'd0: begin
				cur_ch = cur_pix[23:16];
				nxt_ch = nxt_pix[23:16];
			end
			2'd1: begin
				cur_ch = cur_pix[15:8];
				nxt_ch = nxt_pix[15:8];
			end
			2'd2: begin
				cur_ch = cur_pix[7:0];
				nxt_ch = nxt_pix[7:0];
			end
			default: begin
				cur_ch = 8'd0;
				nxt_ch = 8'd0;
			end
		endcase
		mul_a = cnt_q[0] ? nxt_ch : cur_ch;
		mul_b = cnt_q[0] ? w : (9'd256 - w);
		prod  = 17'(mul_a) * 17'(mul_b);
		sum   = acc_q + prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= 4'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					cnt_q <= 4'd0;
					if (start) begin
						state_q <= U_DIV;
					end
				end
				U_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= 4'd0;
						state_q <= U_MIX;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				U_MIX: begin
					if (cnt_q == MIX_LAST) begin
						cnt_q   <= 4'd0;
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (start) begin
					rem_q <= elapsed;
					per_q <= period;
					quo_q <= 8'd0;
					sat_q <= 1'b0;
				end
			end
			U_DIV: begin
				if (cnt_q == 4'd0) begin
					sat_q <= div_ge;
				end else if (div_ge) begin
					rem_q <= div_diff;
					quo_q <= {quo_q[6:0], 1'b1};
				end else begin
					rem_q <= div_a;
					quo_q <= {quo_q[6:0], 1'b0};
				end
			end
			U_MIX: begin
				if (!cnt_q[0]) begin
					acc_q <= prod;
				end else begin
					case (ch)
						2'd0:    mix_q[23:16] <= sum[15:8];
						2'd1:    mix_q[15:8]  <= sum[15:8];
						2'd2:    mix_q[7:0]   <= sum[15:8];
						default: mix_q        <= mix_q;
					endcase
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign mix_pix  = mix_q;
	assign sts.busy = (state_q != U_IDLE);
	assign sts.done = done_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == U_IDLE)
		else $error("blend unit started while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("blend done held longer than one cycle");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == U_DIV) |-> cnt_q <= DIV_LAST)
		else $error("divider step count overran");

	a_mix_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == U_MIX && cnt_q == MIX_LAST) |=> done_q && state_q == U_IDLE)
		else $error("mix sequence did not finish");

endmodule
`default_nettype wire

### sv/led_frame_player_crossfade.sv
`timescale 1ns / 1ps
`default_nettype none
// Write, tick, out-of-range read and unused op: straight to the finish state.
// Plain read: one pixel store read of the current frame, then the finish state.
// Blended read: a second store read of the next frame, then a wait for the 9-step divider and the
// 6-step channel multiply of the shared blend unit. One request is in flight at a time.
// Reset restores the configuration defaults and clears frame index, elapsed time and the
// result valid flag; the pixel store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// LED frame player with crossfade
// Stores RGB frames of an LED grid, steps through them on time ticks and
// returns pixels of the current frame, optionally faded toward the next one.
// ----------------------------------------------------------------------------
module led_frame_player_crossfade #(
	parameter int MAX_FRAMES = lfpc_pkg::LFPC_MAX_FRAMES,
	parameter int MAX_ROWS   = lfpc_pkg::LFPC_MAX_ROWS,
	parameter int MAX_COLS   = lfpc_pkg::LFPC_MAX_COLS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	lfpc_cmd_if.sink                              cmd,
	lfpc_rsp_if.source                            rsp,
	input  logic                                  cfg_we,
	input  logic [lfpc_pkg::LFPC_CFG_IDX_W-1:0]   cfg_idx,
	input  logic [lfpc_pkg::LFPC_CFG_DATA_W-1:0]  cfg_wdata
);
	import lfpc_pkg::*;

	localparam int FA     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int RA     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CA     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW     = FA + RA + CA;
	localparam int DEPTH  = 2 ** AW;
	// The frame count register tops out at 31, so the index never needs more than 5 bits.
	localparam int FIDX_W = (MAX_FRAMES >= 32) ? LFPC_NF_W : FA;
	localparam logic [LFPC_EXT_W-1:0] MAXF_X = LFPC_EXT_W'(MAX_FRAMES);
	localparam logic [LFPC_EXT_W-1:0] MAXR_X = LFPC_EXT_W'(MAX_ROWS);
	localparam logic [LFPC_EXT_W-1:0] MAXC_X = LFPC_EXT_W'(MAX_COLS);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ   = 4'b0010,
		S_BLEND  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	// Configuration
	logic [LFPC_NF_W-1:0]      num_frames_q;
	logic [LFPC_PERIOD_W-1:0]  period_q;
	logic [5:0]                rows_q;
	logic [5:0]                cols_q;
	logic                      fwd_q;
	logic                      blend_q;
	logic                      play_q;

	// Playback and sequencing
	state_t                    state_q;
	logic [1:0]                phase_q;
	logic [FIDX_W-1:0]         frame_idx_q;
	logic [LFPC_ELAPSED_W-1:0] elapsed_q;
	logic                      out_valid_q;

	// Request payload and result
	logic [5:0]                row_q;
	logic [5:0]                col_q;
	logic [LFPC_PIX_W-1:0]     rdata_q;
	logic [LFPC_PIX_W-1:0]     cur_pix_q;
	logic [LFPC_PIX_W-1:0]     nxt_pix_q;
	logic [LFPC_PIX_W-1:0]     res_rgb_q;
	logic                      res_chg_q;
	logic                      res_inr_q;
	lfpc_out_t                 rsp_data_q;

	logic [LFPC_PIX_W-1:0]     store_mem [DEPTH];

	logic                      cmd_acc;
	logic                      out_load;
	logic [LFPC_EXT_W-1:0]     nf_x;
	logic [LFPC_NF_W-1:0]      nf;
	logic [LFPC_NF_W-1:0]      f5;
	logic [LFPC_NF_W:0]        f5_inc;
	logic [LFPC_NF_W-1:0]      nxt5;
	logic [FIDX_W-1:0]         nxt_frame;
	logic [LFPC_PERIOD_W-1:0]  period_use;
	logic [LFPC_ELAPSED_W:0]   el_sum;
	logic [LFPC_ELAPSED_W-1:0] el_new;
	logic                      tick_run;
	logic                      tick_wrap;
	logic                      is_tick;
	logic                      is_read;
	logic [LFPC_EXT_W-1:0]     in_row_x;
	logic [LFPC_EXT_W-1:0]     in_col_x;
	logic [LFPC_EXT_W-1:0]     in_fsel_x;
	logic                      wr_ok;
	logic                      rd_ok;
	logic                      mem_we;
	logic [AW-1:0]             wr_addr;
	logic [AW-1:0]             rd_addr;
	logic [LFPC_EXT_W-1:0]     rd_frame_x;
	logic [LFPC_EXT_W-1:0]     row_x;
	logic [LFPC_EXT_W-1:0]     col_x;
	logic                      blend_start;
	logic [LFPC_PIX_W-1:0]     mix_pix;
	lfpc_blend_sts_t           bsts;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || rsp.ready);

	always_comb begin
		// Frames in use: zero counts as one, anything above the store size is clipped.
		if (num_frames_q == '0) begin
			nf_x = LFPC_EXT_W'(1);
		end else if (LFPC_EXT_W'(num_frames_q) > MAXF_X) begin
			nf_x = MAXF_X;
		end else begin
			nf_x = LFPC_EXT_W'(num_frames_q);
		end
		nf     = nf_x[LFPC_NF_W-1:0];
		f5     = LFPC_NF_W'(frame_idx_q);
		f5_inc = {1'b0, f5} + (LFPC_NF_W+1)'(1);
		if (fwd_q) begin
			nxt5 = (f5_inc >= {1'b0, nf}) ? '0 : f5_inc[LFPC_NF_W-1:0];
		end else begin
			nxt5 = (f5 == '0 || f5 > nf) ? (nf - LFPC_NF_W'(1)) : (f5 - LFPC_NF_W'(1));
		end
		nxt_frame = FIDX_W'(nxt5);

		period_use = (period_q == '0) ? LFPC_PERIOD_W'(1) : period_q;
		el_sum     = {1'b0, elapsed_q} + (LFPC_ELAPSED_W+1)'(cmd.data.dt);
		el_new     = el_sum[LFPC_ELAPSED_W-1:0];
		tick_run   = play_q && (nf > LFPC_NF_W'(1));
		tick_wrap  = el_new >= {1'b0, period_use};

		is_tick   = (cmd.data.op == OP_TICK);
		is_read   = (cmd.data.op == OP_READ);
		in_row_x  = LFPC_EXT_W'(cmd.data.row);
		in_col_x  = LFPC_EXT_W'(cmd.data.col);
		in_fsel_x = LFPC_EXT_W'(cmd.data.frame_sel);
		wr_ok     = (in_fsel_x < MAXF_X) && (in_row_x < MAXR_X) && (in_col_x < MAXC_X);
		rd_ok     = (in_row_x < MAXR_X) && (in_row_x < LFPC_EXT_W'(rows_q))
		            && (in_col_x < MAXC_X) && (in_col_x < LFPC_EXT_W'(cols_q));

		mem_we  = cmd_acc && (cmd.data.op == OP_WRITE) && wr_ok;
		wr_addr = {in_fsel_x[FA-1:0], in_row_x[RA-1:0], in_col_x[CA-1:0]};

		// The first read phase fetches the current frame, the second the next frame.
		rd_frame_x = (phase_q == 2'd0) ? LFPC_EXT_W'(frame_idx_q) : LFPC_EXT_W'(nxt_frame);
		row_x      = LFPC_EXT_W'(row_q);
		col_x      = LFPC_EXT_W'(col_q);
		rd_addr    = {rd_frame_x[FA-1:0], row_x[RA-1:0], col_x[CA-1:0]};

		blend_start = cmd_acc && is_read && rd_ok && blend_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[wr_addr] <= {cmd.data.red_in, cmd.data.green_in, cmd.data.blue_in};
		end
		rdata_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= LFPC_RST_NUM_FRAMES;
			period_q     <= LFPC_RST_PERIOD;
			rows_q       <= LFPC_RST_ROWS;
			cols_q       <= LFPC_RST_COLS;
			fwd_q        <= 1'b1;
			blend_q      <= 1'b0;
			play_q       <= 1'b1;
			state_q      <= S_IDLE;
			phase_q      <= 2'd0;
			frame_idx_q  <= '0;
			elapsed_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_NUM_FRAMES:   num_frames_q <= cfg_wdata[LFPC_NF_W-1:0];
					CFG_FRAME_PERIOD: period_q     <= cfg_wdata[LFPC_PERIOD_W-1:0];
					CFG_GRID_ROWS:    rows_q       <= cfg_wdata[5:0];
					CFG_GRID_COLS:    cols_q       <= cfg_wdata[5:0];
					CFG_PLAY_FORWARD: fwd_q        <= cfg_wdata[0];
					CFG_BLEND_ENABLE: blend_q      <= cfg_wdata[0];
					CFG_PLAY_ENABLE:  play_q       <= cfg_wdata[0];
					default: begin
					end
				endcase
			end

			// Writing the frame count restarts playback.
			if (cfg_we && cfg_idx == CFG_NUM_FRAMES) begin
				frame_idx_q <= '0;
				elapsed_q   <= '0;
			end else if (cmd_acc && is_tick && tick_run) begin
				if (tick_wrap) begin
					elapsed_q   <= '0;
					frame_idx_q <= nxt_frame;
				end else begin
					elapsed_q <= el_new;
				end
			end

			case (state_q)
				S_IDLE: begin
					phase_q <= 2'd0;
					if (cmd_acc) begin
						state_q <= (is_read && rd_ok) ? S_READ : S_FINISH;
					end
				end
				S_READ: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd1 && !blend_q) begin
						state_q <= S_FINISH;
					end else if (phase_q == 2'd2) begin
						state_q <= S_BLEND;
					end
				end
				S_BLEND: begin
					if (bsts.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			row_q     <= cmd.data.row;
			col_q     <= cmd.data.col;
			res_rgb_q <= '0;
			res_inr_q <= is_read && rd_ok;
			res_chg_q <= is_tick && tick_run && tick_wrap;
		end
		if (state_q == S_READ && phase_q == 2'd1) begin
			cur_pix_q <= rdata_q;
			if (!blend_q) begin
				res_rgb_q <= rdata_q;
			end
		end
		if (state_q == S_READ && phase_q == 2'd2) begin
			nxt_pix_q <= rdata_q;
		end
		if (state_q == S_BLEND && bsts.done) begin
			res_rgb_q <= mix_pix;
		end
		if (out_load) begin
			rsp_data_q.red_out       <= res_rgb_q[23:16];
			rsp_data_q.green_out     <= res_rgb_q[15:8];
			rsp_data_q.blue_out      <= res_rgb_q[7:0];
			rsp_data_q.frame_changed <= res_chg_q;
			rsp_data_q.in_range      <= res_inr_q;
			rsp_data_q.current_frame <= 4'(frame_idx_q);
		end
	end

	lfpc_blend_unit u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (blend_start),
		.elapsed (elapsed_q),
		.period  (period_use),
		.cur_pix (cur_pix_q),
		.nxt_pix (nxt_pix_q),
		.mix_pix (mix_pix),
		.sts     (bsts)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_data_q;

	a_done_in_blend: assert property (@(posedge clk) disable iff (!arst_n)
		bsts.done |-> state_q == S_BLEND)
		else $error("blend result arrived outside the blend wait");

	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !bsts.busy)
		else $error("request taken while the blend unit is busy");

	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		LFPC_NF_W'(frame_idx_q) < nf)
		else $error("frame index beyond frames in use");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result presented without finishing a request");

	a_read_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> phase_q <= 2'd2)
		else $error("read phase overran");

endmodule
`default_nettype wire
